FILE: hw/rtl/fixed_point_alu_core_assert.svh
// Assertion macros shared by the fixed-point ALU RTL.
// Each macro expects clk and rst_n in scope.
`ifndef FIXED_POINT_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_ALU_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes, status codes, field widths and default sizes of the
// fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FIELD_W = 32;
  localparam int KIND_W  = 4;
  localparam int STAT_W  = 2;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [KIND_W-1:0] K_ADD    = 4'd0;
  localparam logic [KIND_W-1:0] K_SUB    = 4'd1;
  localparam logic [KIND_W-1:0] K_MUL    = 4'd2;
  localparam logic [KIND_W-1:0] K_DIV    = 4'd3;
  localparam logic [KIND_W-1:0] K_GT     = 4'd4;
  localparam logic [KIND_W-1:0] K_LT     = 4'd5;
  localparam logic [KIND_W-1:0] K_GE     = 4'd6;
  localparam logic [KIND_W-1:0] K_LE     = 4'd7;
  localparam logic [KIND_W-1:0] K_EQ     = 4'd8;
  localparam logic [KIND_W-1:0] K_NE     = 4'd9;
  localparam logic [KIND_W-1:0] K_MIN    = 4'd10;
  localparam logic [KIND_W-1:0] K_MAX    = 4'd11;
  localparam logic [KIND_W-1:0] K_INC    = 4'd12;
  localparam logic [KIND_W-1:0] K_DEC    = 4'd13;
  localparam logic [KIND_W-1:0] K_TO_INT = 4'd14;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVF  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIVZ = 2'd2;

endpackage

FILE: hw/rtl/fpa_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div_stage
// One registered step of the restoring divider: shifts in one numerator
// bit, trial-subtracts the divisor and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [WORD_WIDTH-1:0]           rem_i,
  input  logic [WORD_WIDTH+FRAC_BITS-1:0] nq_i,
  input  logic [WORD_WIDTH-1:0]           den_i,
  output logic [WORD_WIDTH-1:0]           rem_o,
  output logic [WORD_WIDTH+FRAC_BITS-1:0] nq_o,
  output logic [WORD_WIDTH-1:0]           den_o
);
  import fpa_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int QW = WORD_WIDTH + FRAC_BITS;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  // numerator bits leave at the top of nq, quotient bits enter at the bottom
  always_comb begin
    trial = {rem_i, nq_i[QW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[W-1:0] : trial[W-1:0];
      nq_o  <= {nq_i[QW-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule

FILE: hw/rtl/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed fixed-point ALU: saturating add/sub/inc/dec, rounded multiply and
// divide, comparisons, min/max and integer conversion.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless a valid output is stalled. Results
// pass the input, decode, divider and output registers (Q24.8 by default).
// The restoring divider sets the depth, resolving one quotient bit per
// pipeline stage; every operation travels the same pipeline so results leave
// in order. A stall on a valid output freezes the whole pipeline and is
// passed straight back to in_stall. Multiply and divide round to nearest
// with halves away from zero; out-of-range results saturate with status 1.
module fixed_point_alu_core #(
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fpa_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [fpa_pkg::FIELD_W-1:0]  in_operand_a,
  input  logic signed [fpa_pkg::FIELD_W-1:0]  in_operand_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fpa_pkg::FIELD_W-1:0]  out_result_value,
  output logic                                out_condition,
  output logic [fpa_pkg::STAT_W-1:0]          out_status
);
  import fpa_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int QW = W + F;
  localparam int LW = W / 2;
  localparam int UW = W - LW;
  localparam int PW = 2 * W;
  localparam int FQ = ((PW > QW) ? PW : QW) + 1;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // saturating W-bit add or subtract, returns {ovf, value}
  function automatic logic [W:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) return {1'b1, (s[W] ? MINV : MAXV)};
    return {1'b0, s[W-1:0]};
  endfunction

  // apply sign to a rounded magnitude and saturate, returns {ovf, value}
  function automatic logic [W:0] finish(input logic neg, input logic [FQ-1:0] q);
    logic [FQ-1:0] lim;
    logic [W-1:0]  m;
    lim = neg ? (FQ'(1) << (W - 1)) : ((FQ'(1) << (W - 1)) - FQ'(1));
    m   = q[W-1:0];
    if (q > lim) return {1'b1, (neg ? MINV : MAXV)};
    return {1'b0, (neg ? (~m + W'(1)) : m)};
  endfunction

  logic en;

  // input register
  logic                  s1_vld_r;
  logic [KIND_W-1:0]     s1_kind_r;
  logic signed [W-1:0]   s1_a_r;
  logic signed [W-1:0]   s1_b_r;
  logic signed [63:0]    a_ext;
  logic signed [63:0]    b_ext;

  // decode stage results
  logic [W-1:0]          ma, mb;
  logic [W-1:0]          e_res;
  logic                  e_cond;
  logic [STAT_W-1:0]     e_st;
  logic [W:0]            sat_w;

  // per-stage side band, index 0 is the decode register
  logic [QW:0]           vld_r;
  logic [W-1:0]          res_r   [0:QW];
  logic                  cond_r  [0:QW];
  logic [STAT_W-1:0]     st_r    [0:QW];
  logic                  ismul_r [0:QW];
  logic                  isdiv_r [0:QW];
  logic                  neg_r   [0:QW];
  logic                  dz_r    [0:QW];

  // multiplier
  logic [2*LW-1:0]       pp00_r;
  logic [LW+UW-1:0]      pp01_r, pp10_r;
  logic [2*UW-1:0]       pp11_r;
  logic [PW-1:0]         prod_sum;
  logic [PW-1:0]         prod_r;
  logic [PW+F-1:0]       prod_ext;
  logic [FQ-1:0]         mul_q;
  logic [W:0]            mul_fin;

  // divider
  logic [QW-1:0]         s2_nq_r;
  logic [W-1:0]          s2_den_r;
  logic [W-1:0]          rem_w [0:QW];
  logic [QW-1:0]         nq_w  [0:QW];
  logic [W-1:0]          den_w [0:QW];
  logic                  div_rnd;
  logic [FQ-1:0]         div_q;
  logic [W:0]            div_fin;
  logic signed [W-1:0]   fin_res;
  logic                  fin_cond;
  logic [STAT_W-1:0]     fin_st;
  logic signed [63:0]    fin_ext;

  // output register
  logic                  out_valid_r;
  logic signed [FIELD_W-1:0] out_res_r;
  logic                  out_cond_r;
  logic [STAT_W-1:0]     out_st_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign a_ext = 64'(in_operand_a);
  assign b_ext = 64'(in_operand_b);

  // ---- decode / simple operations -----------------------------------------
  always_comb begin
    ma     = s1_a_r[W-1] ? (~s1_a_r + W'(1)) : s1_a_r;
    mb     = s1_b_r[W-1] ? (~s1_b_r + W'(1)) : s1_b_r;
    e_res  = '0;
    e_cond = 1'b0;
    e_st   = ST_OK;
    sat_w  = '0;
    case (s1_kind_r)
      K_ADD, K_SUB: begin
        sat_w = add_sat(s1_a_r, s1_b_r, s1_kind_r == K_SUB);
        e_res = sat_w[W-1:0];
        e_st  = sat_w[W] ? ST_OVF : ST_OK;
      end
      K_INC, K_DEC: begin
        sat_w = add_sat(s1_a_r, W'(1), s1_kind_r == K_DEC);
        e_res = sat_w[W-1:0];
        e_st  = sat_w[W] ? ST_OVF : ST_OK;
      end
      K_GT:     e_cond = s1_a_r >  s1_b_r;
      K_LT:     e_cond = s1_a_r <  s1_b_r;
      K_GE:     e_cond = s1_a_r >= s1_b_r;
      K_LE:     e_cond = s1_a_r <= s1_b_r;
      K_EQ:     e_cond = s1_a_r == s1_b_r;
      K_NE:     e_cond = s1_a_r != s1_b_r;
      K_MIN:    e_res  = (s1_a_r < s1_b_r) ? s1_a_r : s1_b_r;
      K_MAX:    e_res  = (s1_a_r > s1_b_r) ? s1_a_r : s1_b_r;
      K_TO_INT: e_res  = s1_a_r >>> F;
      default:  e_res  = '0;
    endcase
  end

  // ---- multiplier sum and rounding ----------------------------------------
  always_comb begin
    prod_sum = (PW'(pp11_r) << (2 * LW)) + (PW'(pp01_r) << LW) + (PW'(pp10_r) << LW)
             + PW'(pp00_r);
    prod_ext = (PW + F)'(prod_r);
    mul_q    = FQ'(prod_ext[PW+F-1:F]) + FQ'(prod_ext[F-1]);
    mul_fin  = finish(neg_r[1], mul_q);
  end

  // ---- divider array ------------------------------------------------------
  assign rem_w[0] = '0;
  assign nq_w[0]  = s2_nq_r;
  assign den_w[0] = s2_den_r;

  for (genvar j = 0; j < QW; j++) begin : g_div
    fpa_div_stage #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_stage (
      .clk  (clk),
      .en   (en),
      .rem_i(rem_w[j]),
      .nq_i (nq_w[j]),
      .den_i(den_w[j]),
      .rem_o(rem_w[j+1]),
      .nq_o (nq_w[j+1]),
      .den_o(den_w[j+1])
    );
  end

  // ---- final selection ----------------------------------------------------
  always_comb begin
    // round up when twice the remainder reaches the divisor
    div_rnd  = {rem_w[QW], 1'b0} >= {1'b0, den_w[QW]};
    div_q    = FQ'(nq_w[QW]) + FQ'(div_rnd);
    div_fin  = finish(neg_r[QW], div_q);
    fin_res  = res_r[QW];
    fin_cond = cond_r[QW];
    fin_st   = st_r[QW];
    if (isdiv_r[QW]) begin
      if (dz_r[QW]) begin
        fin_res = '0;
        fin_st  = ST_DIVZ;
      end else begin
        fin_res = div_fin[W-1:0];
        fin_st  = div_fin[W] ? ST_OVF : ST_OK;
      end
    end
    fin_ext = 64'(fin_res);
  end

  // ---- control registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= in_valid;
      vld_r       <= {vld_r[QW-1:0], s1_vld_r};
      out_valid_r <= vld_r[QW];
    end
  end

  // ---- payload registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= in_kind;
      s1_a_r    <= a_ext[W-1:0];
      s1_b_r    <= b_ext[W-1:0];

      res_r[0]   <= e_res;
      cond_r[0]  <= e_cond;
      st_r[0]    <= e_st;
      ismul_r[0] <= s1_kind_r == K_MUL;
      isdiv_r[0] <= s1_kind_r == K_DIV;
      neg_r[0]   <= s1_a_r[W-1] ^ s1_b_r[W-1];
      dz_r[0]    <= mb == '0;
      pp00_r     <= ma[LW-1:0] * mb[LW-1:0];
      pp01_r     <= ma[LW-1:0] * mb[W-1:LW];
      pp10_r     <= ma[W-1:LW] * mb[LW-1:0];
      pp11_r     <= ma[W-1:LW] * mb[W-1:LW];
      s2_nq_r    <= {ma, {F{1'b0}}};
      s2_den_r   <= mb;

      prod_r <= prod_sum;

      for (int j = 0; j < QW; j++) begin
        cond_r[j+1]  <= cond_r[j];
        ismul_r[j+1] <= ismul_r[j];
        isdiv_r[j+1] <= isdiv_r[j];
        neg_r[j+1]   <= neg_r[j];
        dz_r[j+1]    <= dz_r[j];
        // the multiply result joins the side band after its rounding stage
        if (j == 1 && ismul_r[1]) begin
          res_r[j+1] <= mul_fin[W-1:0];
          st_r[j+1]  <= mul_fin[W] ? ST_OVF : ST_OK;
        end else begin
          res_r[j+1] <= res_r[j];
          st_r[j+1]  <= st_r[j];
        end
      end

      out_res_r  <= fin_ext[FIELD_W-1:0];
      out_cond_r <= fin_cond;
      out_st_r   <= fin_st;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_condition    = out_cond_r;
  assign out_status       = out_st_r;

`include "fixed_point_alu_core_assert.svh"

  `FPA_ASSERT_IMP(a_divz_zero, out_valid && out_status == ST_DIVZ,
                  out_result_value == '0 && !out_condition, "div by zero result not zero")
  `FPA_ASSERT_IMP(a_cond_clean, out_valid && out_condition,
                  out_status == ST_OK && out_result_value == '0, "comparison with payload")
  `FPA_ASSERT_IMP(a_status_code, out_valid,
                  out_status == ST_OK || out_status == ST_OVF || out_status == ST_DIVZ,
                  "unknown status code")
  `FPA_ASSERT_NXT(a_stall_freeze, out_valid && out_stall && vld_r[QW],
                  vld_r[QW] && out_valid, "pipeline moved under stall")

endmodule
